// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check sampled on the rising clock edge, switched off while reset is high
`define UGPA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check that also holds during reset
`define UGPA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/ugpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ugpa_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 1024;

   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 48;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [15:0] REPLACEMENT = 16'hFFFD;

   typedef enum logic [1:0] {
      ACT_BYTE  = 2'd0,
      ACT_LOAD  = 2'd1,
      ACT_START = 2'd2
   } action_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FIRST_CODE    = 3'd0,
      CSR_LAST_CODE     = 3'd1,
      CSR_FIXED_WIDTH   = 3'd2,
      CSR_FONT_HEIGHT   = 3'd3,
      CSR_TABLE_ENABLED = 3'd4
   } csr_index_type;

endpackage

`default_nettype wire

// ===== hdl/utf8_glyph_pen_advance.sv =====
`timescale 1ns / 1ps
`default_nettype none

// UTF-8 to 16-bit code point decoder with pen placement. One request enters per cycle
// (req_tuser: 0 text byte, 1 width table load, 2 start string with origin); a text byte
// that completes a character gives one response, registered by both stages, carrying the
// code point (U+FFFD for unknown, out of font range or zero-width glyphs) and its draw x/y.
// Throughput is one request per clock; the only stall is response back-pressure. The first
// stage decodes the byte and reads the glyph width table (TABLE_DEPTH x 8 bit memory with
// two registered read ports), the second resolves the advance and moves the pen. Table
// entries are undefined until loaded. Configuration writes on the csr_ port are taken
// whenever not in reset and must only be made while no request is in flight.
module utf8_glyph_pen_advance #(
   parameter int TABLE_DEPTH = ugpa_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // byte_value[7:0], entry_index[17:8], entry_width[25:18], origin_x[41:26],
   // origin_y[57:42], zero[63:58]
   input  logic [ugpa_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // action[1:0]
   input  logic [1:0]                         req_tuser,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // code_point[15:0], draw_x[31:16], draw_y[47:32]
   output logic [ugpa_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ugpa_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ugpa_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int SLOT_W = 17;
   localparam logic [SLOT_W-1:0] DEPTH_LIMIT = SLOT_W'(TABLE_DEPTH);

   // request fields
   ugpa_pkg::action_type action;
   logic [7:0]  byte_value;
   logic [9:0]  entry_index;
   logic [7:0]  entry_width;
   logic [15:0] origin_x;
   logic [15:0] origin_y;

   assign action      = ugpa_pkg::action_type'(req_tuser);
   assign byte_value  = req_tdata[7:0];
   assign entry_index = req_tdata[17:8];
   assign entry_width = req_tdata[25:18];
   assign origin_x    = req_tdata[41:26];
   assign origin_y    = req_tdata[57:42];

   // configuration registers
   logic [15:0] first_code_ff;
   logic [15:0] last_code_ff;
   logic [7:0]  fixed_width_ff;
   logic [9:0]  font_height_ff;
   logic        table_enabled_ff;

   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_code_ff    <= 16'd0;
         last_code_ff     <= 16'd255;
         fixed_width_ff   <= 8'd8;
         font_height_ff   <= 10'd16;
         table_enabled_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (ugpa_pkg::csr_index_type'(csr_index))
            ugpa_pkg::CSR_FIRST_CODE:    first_code_ff    <= csr_data;
            ugpa_pkg::CSR_LAST_CODE:     last_code_ff     <= csr_data;
            ugpa_pkg::CSR_FIXED_WIDTH:   fixed_width_ff   <= csr_data[7:0];
            ugpa_pkg::CSR_FONT_HEIGHT:   font_height_ff   <= csr_data[9:0];
            ugpa_pkg::CSR_TABLE_ENABLED: table_enabled_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // handshake
   logic req_accept;
   logic s1_valid_ff;
   logic s1_start_ff;
   logic rsp_valid_ff;
   logic out_free;
   logic s1_go;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_go      = s1_valid_ff && (s1_start_ff || out_free);
   assign req_tready = !reset && (!s1_valid_ff || s1_go);
   assign req_accept = req_tvalid && req_tready;

   // utf-8 decoder state
   logic [2:0]  bytes_left_ff, bytes_left_in;
   logic [15:0] partial_ff, partial_in;
   logic        force_ff, force_in;
   logic        dec_emit;
   logic [15:0] dec_code;
   logic [15:0] partial_shift;

   assign partial_shift = {partial_ff[9:0], byte_value[5:0]};

   always_comb begin
      bytes_left_in = bytes_left_ff;
      partial_in    = partial_ff;
      force_in      = force_ff;
      dec_emit      = 1'b0;
      dec_code      = {8'h00, byte_value};
      if (bytes_left_ff == 3'd0) begin
         // ascii, stray continuation or 0xfe/0xff stand for themselves
         if (!byte_value[7] || byte_value[7:6] == 2'b10 || byte_value[7:1] == 7'h7F) begin
            dec_emit = 1'b1;
         end else begin
            if (byte_value[7:5] == 3'b110) begin
               partial_in    = {11'd0, byte_value[4:0]};
               bytes_left_in = 3'd1;
               force_in      = 1'b0;
            end else if (byte_value[7:4] == 4'b1110) begin
               partial_in    = {12'd0, byte_value[3:0]};
               bytes_left_in = 3'd2;
               force_in      = 1'b0;
            end else begin
               // four- to six-byte sequences are consumed and replaced
               partial_in = 16'd0;
               force_in   = 1'b1;
               if (byte_value[7:3] == 5'b11110) begin
                  bytes_left_in = 3'd3;
               end else if (byte_value[7:2] == 6'b111110) begin
                  bytes_left_in = 3'd4;
               end else begin
                  bytes_left_in = 3'd5;
               end
            end
            if (req_tlast) begin
               bytes_left_in = 3'd0;
               partial_in    = 16'd0;
               force_in      = 1'b0;
            end
         end
      end else begin
         bytes_left_in = bytes_left_ff - 3'd1;
         partial_in    = partial_shift;
         if (bytes_left_ff == 3'd1) begin
            dec_emit      = 1'b1;
            dec_code      = force_ff ? ugpa_pkg::REPLACEMENT : partial_shift;
            partial_in    = 16'd0;
            force_in      = 1'b0;
         end else if (req_tlast) begin
            bytes_left_in = 3'd0;
            partial_in    = 16'd0;
            force_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= 3'd0;
         partial_ff    <= 16'd0;
         force_ff      <= 1'b0;
      end else if (req_accept) begin
         if (action == ugpa_pkg::ACT_BYTE) begin
            bytes_left_ff <= bytes_left_in;
            partial_ff    <= partial_in;
            force_ff      <= force_in;
         end else if (action == ugpa_pkg::ACT_START) begin
            bytes_left_ff <= 3'd0;
            partial_ff    <= 16'd0;
            force_ff      <= 1'b0;
         end
      end
   end

   // table slots for the decoded code and for the replacement glyph
   logic                in_range_a;
   logic                in_range_b;
   logic [SLOT_W-1:0]   slot_a;
   logic [SLOT_W-1:0]   slot_b;
   logic                hit_a;
   logic                hit_b;
   logic [SLOT_W-1:0]   load_slot;
   logic                load_wr;

   assign in_range_a = (dec_code >= first_code_ff) && (dec_code <= last_code_ff);
   assign in_range_b = (ugpa_pkg::REPLACEMENT >= first_code_ff)
                    && (ugpa_pkg::REPLACEMENT <= last_code_ff);
   assign slot_a     = SLOT_W'(dec_code) - SLOT_W'(first_code_ff);
   assign slot_b     = SLOT_W'(ugpa_pkg::REPLACEMENT) - SLOT_W'(first_code_ff);
   assign hit_a      = table_enabled_ff && in_range_a && (slot_a < DEPTH_LIMIT);
   assign hit_b      = table_enabled_ff && in_range_b && (slot_b < DEPTH_LIMIT);
   assign load_slot  = SLOT_W'(entry_index);
   assign load_wr    = req_accept && (action == ugpa_pkg::ACT_LOAD)
                    && (load_slot < DEPTH_LIMIT);

   // glyph width table
   logic [7:0] width_mem [TABLE_DEPTH];
   logic [7:0] rd_a_ff;
   logic [7:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (load_wr) begin
         width_mem[load_slot[ADDR_W-1:0]] <= entry_width;
      end
      if (req_accept) begin
         rd_a_ff <= width_mem[slot_a[ADDR_W-1:0]];
         rd_b_ff <= width_mem[slot_b[ADDR_W-1:0]];
      end
   end

   // first stage register
   logic        s1_enter;
   logic [15:0] s1_code_ff;
   logic        s1_in_range_ff;
   logic        s1_hit_a_ff;
   logic        s1_hit_b_ff;
   logic [15:0] s1_origin_x_ff;
   logic [15:0] s1_origin_y_ff;

   assign s1_enter = req_accept && ((action == ugpa_pkg::ACT_BYTE && dec_emit)
                                 || action == ugpa_pkg::ACT_START);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_enter) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_enter) begin
         s1_start_ff    <= (action == ugpa_pkg::ACT_START);
         s1_code_ff     <= dec_code;
         s1_in_range_ff <= in_range_a;
         s1_hit_a_ff    <= hit_a;
         s1_hit_b_ff    <= hit_b;
         s1_origin_x_ff <= origin_x;
         s1_origin_y_ff <= origin_y;
      end
   end

   // second stage: resolve glyph and advance
   logic        zero_width;
   logic        use_repl;
   logic [15:0] final_code;
   logic [7:0]  advance;

   assign zero_width = s1_hit_a_ff && (rd_a_ff == 8'd0);
   assign use_repl   = !s1_in_range_ff || zero_width;
   assign final_code = use_repl ? ugpa_pkg::REPLACEMENT : s1_code_ff;

   always_comb begin
      if (use_repl) begin
         advance = s1_hit_b_ff ? rd_b_ff : fixed_width_ff;
      end else begin
         advance = s1_hit_a_ff ? rd_a_ff : fixed_width_ff;
      end
   end

   logic [15:0] pen_ff;
   logic [15:0] origin_x_ff;
   logic [15:0] origin_y_ff;
   logic [15:0] code_out_ff;
   logic [15:0] draw_x_ff;
   logic [15:0] draw_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff       <= 16'd0;
         origin_x_ff  <= 16'd0;
         origin_y_ff  <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_go && s1_start_ff) begin
            origin_x_ff <= s1_origin_x_ff;
            origin_y_ff <= s1_origin_y_ff;
            pen_ff      <= 16'd0;
         end else if (s1_go) begin
            pen_ff <= pen_ff + 16'(advance);
         end
         if (s1_go && !s1_start_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && !s1_start_ff) begin
         code_out_ff <= final_code;
         draw_x_ff   <= origin_x_ff + pen_ff;
         draw_y_ff   <= origin_y_ff + 16'(font_height_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {draw_y_ff, draw_x_ff, code_out_ff};

endmodule

`default_nettype wire

// ===== hdl/ugpa_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ugpa_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [ugpa_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // a stalled response keeps its payload
   `UGPA_ASSERT(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "response changed while stalled")

   // a fresh response is preceded by a taken request
   `UGPA_ASSERT(a_rsp_latency, clock, reset, $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2), "response without a matching request")

   // reset empties the result register and closes the request side
   `UGPA_ASSERT_ALWAYS(a_reset_flush, clock, reset |=> !rsp_tvalid, "response valid after reset")
   `UGPA_ASSERT_ALWAYS(a_reset_ready, clock, reset |-> !req_tready, "request taken during reset")

endmodule

bind utf8_glyph_pen_advance ugpa_checker u_ugpa_checker (.*);

`default_nettype wire
